// ===== src/pcmx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmx_pkg
// Shared types, register indexes and format codes for the PCM export block.
// ----------------------------------------------------------------------------
package pcmx_pkg;

   localparam int unsigned NumLanes = 2;

   localparam logic [1:0] FMT_INT16 = 2'd0;
   localparam logic [1:0] FMT_INT24 = 2'd1;
   localparam logic [1:0] FMT_INT32 = 2'd2;
   localparam logic [1:0] FMT_FLT32 = 2'd3;

   localparam logic [1:0] REG_OUT_FORMAT = 2'd0;
   localparam logic [1:0] REG_OUT_CHANNELS = 2'd1;
   localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd2;
   localparam logic [1:0] REG_ALIGN_WORDS = 2'd3;

   typedef struct packed {
      logic [1:0] out_format;
      logic       align_words;
   } cfg_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  bytes;
      logic        flag;
   } lane_res_type;

endpackage

// ===== src/pcmx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmx_if
// Valid/ready channel interfaces for frames, words and register writes.
// ----------------------------------------------------------------------------
interface pcmx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_left;
   logic [31:0] sample_right;
   logic        last_frame;
   modport source (output valid, sample_left, sample_right, last_frame, input ready);
   modport sink (input valid, sample_left, sample_right, last_frame, output ready);
endinterface

interface pcmx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pcm_word;
   logic [2:0]  byte_count;
   logic        last_word;
   logic        overflow_seen;
   modport source (output valid, pcm_word, byte_count, last_word, overflow_seen,
                   input ready);
   modport sink (input valid, pcm_word, byte_count, last_word, overflow_seen,
                 output ready);
endinterface

interface pcmx_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pcm_float_to_int_export.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_float_to_int_export
// Converts stereo float frames to int16/int24/int32 or float PCM words.
// ----------------------------------------------------------------------------
// Both samples of a frame are converted combinationally by two lanes and held
// in a frame register; the merge stage sends them out one word per cycle while
// rsp.ready is high, two words for a stereo frame and one for a mono-out
// frame. A new frame is taken as soon as the held frame's final word leaves.
// The overflow flag is sticky across frames and clears after a frame marked last.
module pcm_float_to_int_export
   import pcmx_pkg::*;
(
   input logic       clock,
   input logic       reset,
   pcmx_req_if.sink  req,
   pcmx_rsp_if.source rsp,
   pcmx_csr_if.sink  csr
);

   cfg_type      cfg;
   logic [1:0]   out_ch_ff;
   logic [1:0]   src_ch_ff;
   logic [31:0]  right_smp;
   lane_res_type res0, res1;

   logic         full_ff, full_in;
   logic         sel_ff, sel_in;
   logic         two_ff;
   logic         last_ff;
   logic         flag0_ff, flag1_ff;
   lane_res_type hold0_ff, hold1_ff;
   logic         sticky_ff, sticky_in;
   logic         take, give, final_word;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg.out_format <= FMT_INT16;
         cfg.align_words <= 1'b0;
         out_ch_ff <= 2'd2;
         src_ch_ff <= 2'd2;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_OUT_FORMAT: cfg.out_format <= csr.data[1:0];
            REG_OUT_CHANNELS: out_ch_ff <= csr.data[1:0];
            REG_SOURCE_CHANNELS: src_ch_ff <= csr.data[1:0];
            default: cfg.align_words <= csr.data[0];
         endcase
      end
   end

   assign right_smp = (src_ch_ff < 2'd2) ? req.sample_left : req.sample_right;

   pcmx_lane u_lane0 (.sample(req.sample_left), .cfg(cfg), .res(res0));
   pcmx_lane u_lane1 (.sample(right_smp), .cfg(cfg), .res(res1));

   assign final_word = two_ff ? sel_ff : 1'b1;
   assign give = full_ff && rsp.ready;
   assign req.ready = !full_ff || (rsp.ready && final_word);
   assign take = req.valid && req.ready;

   always_comb begin
      full_in = full_ff;
      sel_in = sel_ff;
      sticky_in = sticky_ff;
      if (give) begin
         sel_in = 1'b1;
         if (final_word) begin
            full_in = 1'b0;
            sticky_in = last_ff ? 1'b0 : flag1_ff;
         end
      end
      if (take) begin
         full_in = 1'b1;
         sel_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         sel_ff <= 1'b0;
         sticky_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         sel_ff <= sel_in;
         sticky_ff <= sticky_in;
      end
   end

   // sticky bit per word: prior state plus lanes up to this word
   always_ff @(posedge clock) begin
      if (take) begin
         hold0_ff <= res0;
         hold1_ff <= res1;
         two_ff <= (out_ch_ff >= 2'd2);
         last_ff <= req.last_frame;
         flag0_ff <= sticky_in | res0.flag;
         flag1_ff <= sticky_in | res0.flag | ((out_ch_ff >= 2'd2) & res1.flag);
      end
   end

   assign rsp.valid = full_ff;
   assign rsp.pcm_word = sel_ff ? hold1_ff.word : hold0_ff.word;
   assign rsp.byte_count = sel_ff ? hold1_ff.bytes : hold0_ff.bytes;
   assign rsp.last_word = last_ff && final_word;
   assign rsp.overflow_seen = sel_ff ? flag1_ff : flag0_ff;

   a_sel_only_stereo: assert property (@(posedge clock) disable iff (reset)
      (full_ff && sel_ff) |-> two_ff) else $error("second word on mono frame");
   a_no_take_midframe: assert property (@(posedge clock) disable iff (reset)
      (full_ff && !final_word) |-> !req.ready) else $error("frame overrun");
   a_flag_monotone: assert property (@(posedge clock) disable iff (reset)
      (full_ff && sel_ff && flag0_ff) |-> flag1_ff) else $error("flag dropped");

endmodule

// ===== src/pcmx_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmx_lane
// One float to PCM converter: scale, truncate, clamp and overflow detect.
// ----------------------------------------------------------------------------
module pcmx_lane
   import pcmx_pkg::*;
(
   input  logic [31:0]  sample,
   input  cfg_type      cfg,
   output lane_res_type res
);

   logic        sgn;
   logic [7:0]  expo;
   logic        is_nan;
   logic [23:0] mant;
   logic [7:0]  scale_e;
   logic [8:0]  e2;
   logic [32:0] mag;
   logic        big;
   logic [32:0] clampv;
   logic [32:0] warnp;
   logic [32:0] warnn;
   logic [32:0] outm;
   logic        flg;
   logic [31:0] sword;

   assign sgn = sample[31];
   assign expo = sample[30:23];
   assign mant = {1'b1, sample[22:0]};
   assign is_nan = (expo == 8'hff) && (sample[22:0] != 23'd0);

   always_comb begin
      unique case (cfg.out_format)
         FMT_INT16: begin
            scale_e = 8'd15; clampv = 33'd32766; warnp = 33'd32770; warnn = 33'd32770;
         end
         FMT_INT24: begin
            scale_e = 8'd23; clampv = 33'd8388606;
            warnp = 33'd8388610; warnn = 33'd8388610;
         end
         default: begin
            scale_e = 8'd31; clampv = 33'h7fffffff;
            warnp = 33'h7fffffff; warnn = 33'h80000000;
         end
      endcase
   end

   // value = mant * 2^(expo - 150 + scale_e); magnitude of 2^33 or more only matters as big
   always_comb begin
      e2 = {1'b0, expo} + {1'b0, scale_e};
      big = 1'b0;
      mag = 33'd0;
      if (expo == 8'd0) begin
         mag = 33'd0;
      end else if (e2 >= 9'd160) begin
         big = 1'b1;
      end else if (e2 >= 9'd150) begin
         mag = {9'd0, mant} << (e2 - 9'd150);
      end else if (e2 >= 9'd126) begin
         mag = {9'd0, mant} >> (9'd150 - e2);
      end
   end

   always_comb begin
      flg = 1'b0;
      outm = mag;
      if (is_nan) begin
         outm = 33'd0;
      end else if (big || mag > clampv) begin
         outm = clampv;
         flg = sgn ? (big || mag > warnn) : (big || mag > warnp);
      end
      sword = sgn ? 32'd0 - outm[31:0] : outm[31:0];
   end

   always_comb begin
      res.flag = 1'b0;
      unique case (cfg.out_format)
         FMT_INT16: begin
            res.word = {16'd0, sword[15:0]};
            res.bytes = cfg.align_words ? 3'd4 : 3'd2;
            res.flag = flg;
         end
         FMT_INT24: begin
            res.word = {8'd0, sword[23:0]};
            res.bytes = cfg.align_words ? 3'd4 : 3'd3;
            res.flag = flg;
         end
         FMT_INT32: begin
            res.word = sword;
            res.bytes = 3'd4;
            res.flag = flg;
         end
         default: begin
            res.word = sample;
            res.bytes = 3'd4;
         end
      endcase
   end

endmodule

// ===== bench/tb_pcmx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcmx_checker
// Watches the frame, word and register channels of the PCM export block,
// predicts every output word from accepted frames and compares field by field.
// ----------------------------------------------------------------------------
module tb_pcmx_checker
   import pcmx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pcmx_req_if        req,
   pcmx_rsp_if        rsp,
   pcmx_csr_if        csr,
   output int         fail_count,
   output int         pending
);

   typedef struct {
      logic [31:0] word;
      logic [2:0]  bytes;
      logic        last;
      logic        flag;
   } pcm_word_type;

   pcm_word_type word_q[$];
   logic [1:0] fmt_r;
   logic [1:0] och_r;
   logic [1:0] sch_r;
   logic       align_r;
   logic       sticky_r;

   assign pending = word_q.size();

   // scaled value truncated toward zero, saturated at 2^40
   function automatic longint trunc_scaled(input logic [31:0] bits, input int sh);
      logic [7:0]  e;
      logic [23:0] m;
      longint      mag;
      int          p;
      e = bits[30:23];
      m = {(e != 0), bits[22:0]};
      if (e == 8'hff) begin
         mag = 64'd1 << 40;
      end else begin
         p = int'(e) - 150 + sh;
         if (e == 0) p = -149 + sh;
         if (p >= 17) mag = 64'd1 << 40;
         else if (p >= 0) mag = longint'(m) << p;
         else if (p > -64) mag = longint'(m) >> (-p);
         else mag = 0;
         if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      end
      return bits[31] ? -mag : mag;
   endfunction

   function automatic void convert_sample(input logic [31:0] bits,
                                          output logic [31:0] w, output logic [2:0] b);
      longint t;
      longint c;
      longint wp;
      longint wn;
      int     sh;
      logic   nan;
      nan = (bits[30:23] == 8'hff) && (bits[22:0] != 0);
      case (fmt_r)
         FMT_INT16: begin sh = 15; c = 32766; wp = 32770; wn = 32770; end
         FMT_INT24: begin sh = 23; c = 8388606; wp = 8388610; wn = 8388610; end
         FMT_INT32: begin sh = 31; c = 64'h7fffffff; wp = 64'h7fffffff; wn = 64'h80000000; end
         default: begin sh = 0; c = 0; wp = 0; wn = 0; end
      endcase
      if (fmt_r == FMT_FLT32) begin
         w = bits;
         b = 3'd4;
         return;
      end
      t = nan ? 0 : trunc_scaled(bits, sh);
      if (t > c) begin
         if (t > wp) sticky_r = 1'b1;
         t = c;
      end else if (t < -c) begin
         if (t < -wn) sticky_r = 1'b1;
         t = -c;
      end
      case (fmt_r)
         FMT_INT16: begin w = {16'd0, t[15:0]}; b = align_r ? 3'd4 : 3'd2; end
         FMT_INT24: begin w = {8'd0, t[23:0]}; b = align_r ? 3'd4 : 3'd3; end
         default: begin w = t[31:0]; b = 3'd4; end
      endcase
   endfunction

   task automatic predict_frame(input logic [31:0] l, input logic [31:0] r,
                                input logic last);
      int           n;
      pcm_word_type e;
      n = (och_r >= 2) ? 2 : 1;
      if (sch_r < 2) r = l;
      for (int k = 0; k < n; k++) begin
         convert_sample(k == 0 ? l : r, e.word, e.bytes);
         e.last = last && (k == n - 1);
         e.flag = sticky_r;
         word_q.push_back(e);
      end
      if (last) sticky_r = 1'b0;
   endtask

   always @(posedge clock) begin
      pcm_word_type e;
      int           errs;
      if (reset) begin
         fmt_r <= FMT_INT16;
         och_r <= 2'd2;
         sch_r <= 2'd2;
         align_r <= 1'b0;
         sticky_r = 1'b0;
         word_q.delete();
         fail_count <= 0;
      end else begin
         errs = 0;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_OUT_FORMAT: fmt_r <= csr.data[1:0];
               REG_OUT_CHANNELS: och_r <= csr.data[1:0];
               REG_SOURCE_CHANNELS: sch_r <= csr.data[1:0];
               REG_ALIGN_WORDS: align_r <= csr.data[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (word_q.size() == 0) begin
               $error("unexpected word %h", rsp.pcm_word);
               errs++;
            end else begin
               e = word_q.pop_front();
               if (rsp.pcm_word !== e.word) begin
                  $error("pcm_word exp %h got %h", e.word, rsp.pcm_word);
                  errs++;
               end
               if (rsp.byte_count !== e.bytes) begin
                  $error("byte_count exp %0d got %0d", e.bytes, rsp.byte_count);
                  errs++;
               end
               if (rsp.last_word !== e.last) begin
                  $error("last_word exp %0d got %0d", e.last, rsp.last_word);
                  errs++;
               end
               if (rsp.overflow_seen !== e.flag) begin
                  $error("overflow_seen exp %0d got %0d", e.flag, rsp.overflow_seen);
                  errs++;
               end
            end
         end
         if (req.valid && req.ready)
            predict_frame(req.sample_left, req.sample_right, req.last_frame);
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives float frames and register writes into the PCM export block under
// varying idle and stall patterns; the checker judges every output word.
// ----------------------------------------------------------------------------
module tb_top;
   import pcmx_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   send_idle;
   int   recv_stall;

   pcmx_req_if req ();
   pcmx_rsp_if rsp ();
   pcmx_csr_if csr ();

   pcm_float_to_int_export i_dut (.clock(clock), .reset(reset), .req(req.sink),
                                  .rsp(rsp.source), .csr(csr.sink));

   tb_pcmx_checker i_chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
                          .fail_count(fail_count), .pending(pending));

   always #6 clock = ~clock;

   always @(negedge clock)
      rsp.ready <= ($urandom_range(99) >= recv_stall);

   initial begin
      req.valid = 1'b0;
      req.sample_left = '0;
      req.sample_right = '0;
      req.last_frame = 1'b0;
      csr.valid = 1'b0;
      csr.index = REG_OUT_FORMAT;
      csr.data = '0;
      send_idle = 0;
      recv_stall = 0;
   end

   function automatic logic [31:0] rand_sample();
      int     k;
      logic [7:0] e;
      k = $urandom_range(9);
      case (k)
         0: return $urandom();
         1: return {1'($urandom_range(1)), 8'hff, 23'd0};
         2: return {1'($urandom_range(1)), 8'hff, 23'($urandom_range(1, 8388607))};
         3: return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
         4: begin
            e = 8'($urandom_range(125, 127));
            return {1'($urandom_range(1)), e, 23'($urandom())};
         end
         5: return {1'($urandom_range(1)), 8'd127, 23'($urandom_range(0, 64))};
         default: begin
            e = 8'($urandom_range(100, 126));
            return {1'($urandom_range(1)), e, 23'($urandom())};
         end
      endcase
   endfunction

   task automatic send_frame(input logic [31:0] l, input logic [31:0] r, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.sample_left <= l;
      req.sample_right <= r;
      req.last_frame <= last;
      #1;
      while (!req.ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      #1;
      while (!csr.ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input logic [1:0] f, input logic [1:0] oc,
                            input logic [1:0] sc, input logic al);
      wait_idle();
      write_reg(REG_OUT_FORMAT, {30'($urandom()), f});
      write_reg(REG_OUT_CHANNELS, {30'($urandom()), oc});
      write_reg(REG_SOURCE_CHANNELS, {30'($urandom()), sc});
      write_reg(REG_ALIGN_WORDS, {31'($urandom()), al});
      csr.valid <= 1'b0;
   endtask

   logic [31:0] edge_vals[12] = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000,
      32'hbf80_0000, 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001,
      32'h3fff_ffff, 32'h0000_0001, 32'h3f7f_fffe, 32'hffff_ffff};

   initial begin
      @(negedge clock);
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int f = 0; f < 4; f++) begin
         configure(f[1:0], 2'd2, 2'd2, f[0]);
         for (int i = 0; i < 6; i++)
            send_frame(edge_vals[(2 * i) % 12], edge_vals[(2 * i + 1) % 12], i == 5);
      end
      for (int ph = 0; ph < 32; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 69; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 69; end
            default: begin send_idle = 13; recv_stall = 13; end
         endcase
         configure(2'($urandom()), 2'($urandom()), 2'($urandom()), 1'($urandom()));
         for (int i = 0; i < 50; i++)
            send_frame(rand_sample(), rand_sample(), $urandom_range(7) == 0);
      end
      configure(FMT_INT32, 2'd1, 2'd1, 1'b1);
      for (int i = 0; i < 12; i++)
         send_frame(edge_vals[i], edge_vals[11 - i], i == 11);
      wait_idle();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
